@@ hdl/ppgc_pkg.sv @@
`default_nettype none
package ppgc_pkg;

    localparam int MAX_PIXELS      = 4096;
    localparam int NUM_CELLS       = 4;
    localparam int WORDS_PER_PIXEL = 8;
    localparam int TABLE_DEPTH     = 131072;
    localparam int ADDR_W          = $clog2(TABLE_DEPTH);
    localparam int FIFO_DEPTH      = 4;
    localparam int DIV_NUM_W       = 48;
    localparam int DIV_STEPS       = 2;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_CELL  = 2'd1;
    localparam logic [1:0] CFG_IMAGE = 2'd2;

    // calibration modes
    localparam logic [1:0] MODE_PED      = 2'd0;
    localparam logic [1:0] MODE_CELL_PED = 2'd1;
    localparam logic [1:0] MODE_GAIN     = 2'd2;

    // kinds of queued work
    localparam logic [1:0] K_LOAD = 2'd0;
    localparam logic [1:0] K_ERR  = 2'd1;
    localparam logic [1:0] K_PED  = 2'd2;
    localparam logic [1:0] K_GAIN = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ZERO_GAIN = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;

    typedef struct packed {
        logic        opcode;
        logic [16:0] word_address;
        logic [31:0] word_value;
        logic [11:0] pixel_index;
        logic [15:0] signal_sample;
        logic [15:0] gain_sample;
    } t_in_item;

    typedef struct packed {
        logic [11:0] out_index;
        logic [31:0] calibrated;
        logic [1:0]  gain_stage;
        logic [1:0]  status;
    } t_out_item;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       value;
        logic [11:0]       pix;
        logic [15:0]       sig;
        logic [15:0]       gsm;
    } t_task;

endpackage
`default_nettype wire

@@ hdl/pixel_pedestal_gain_calibration_top.sv @@
// pixel pedestal and gain calibration
// input channel: one word per handshake, opcode 0 loads a table word, opcode 1
//   calibrates one pixel and yields exactly one output word
// config channel: index 0 mode, 1 cell select, 2 image size; write only when idle
// output channel: index, calibrated q24.8 value, gain level, status
// the front decodes each word, forms table addresses and range checks it, then
//   queues it in a four-entry queue; the front takes a word whenever the queue
//   has room, so inputs keep flowing while the back is busy or stalled
// the back owns the single-port table and works one queued word at a time:
//   a load writes the table, a pedestal pixel makes one read, an out-of-range
//   pixel makes none, a gain-switching pixel makes four reads (the later addresses
//   picked by earlier compares), then, unless the gain word is zero, runs a
//   2-bit-per-cycle divider
// the result sits in an output register; while the receiver stalls the back
//   holds its finished word and the queue keeps absorbing input until full
// reset (synchronous, active low) clears config to mode 0, cell 0, image 4096
//   and empties the queue; table contents are not cleared and must be loaded
`default_nettype none
module pixel_pedestal_gain_calibration_top (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  ppgc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output ppgc_pkg::t_out_item o_out_data,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire  [1:0]          i_cfg_index,
    input  wire  [15:0]         i_cfg_data
);
    import ppgc_pkg::*;

    // front to queue
    logic  push;
    logic  full;
    t_task front_task;
    // queue to back
    logic  pop;
    logic  task_valid;
    t_task back_task;

    ppgc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push),
        .o_task      (front_task),
        .i_full      (full)
    );

    ppgc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_task),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (task_valid),
        .o_data  (back_task)
    );

    ppgc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task_valid (task_valid),
        .i_task       (back_task),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule
`default_nettype wire

@@ hdl/ppgc_front.sv @@
`default_nettype none
module ppgc_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  ppgc_pkg::t_in_item  i_in_data,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire  [1:0]          i_cfg_index,
    input  wire  [15:0]         i_cfg_data,
    output logic                o_push,
    output ppgc_pkg::t_task     o_task,
    input  wire                 i_full
);
    import ppgc_pkg::*;

    logic [1:0]  r_mode;
    logic [1:0]  r_cell;
    logic [12:0] r_image;
    logic [14:0] cell_prod;
    logic [15:0] cell_addr;
    logic [19:0] base;
    logic        in_image;
    logic        cell_ok;
    logic        accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !i_full;
    assign accept      = i_in_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_PED;
            r_cell  <= '0;
            r_image <= 13'(MAX_PIXELS);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE:  r_mode  <= i_cfg_data[1:0];
                CFG_CELL:  r_cell  <= i_cfg_data[1:0];
                CFG_IMAGE: r_image <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // cell stride address, small multiply
    assign cell_prod = 15'(r_cell) * 15'(r_image);
    assign cell_addr = 16'(cell_prod) + 16'(i_in_data.pixel_index);
    assign base      = 20'(cell_addr) * 20'(WORDS_PER_PIXEL);
    assign cell_ok   = 32'(r_cell) < NUM_CELLS;
    assign in_image  = (13'(i_in_data.pixel_index) < r_image)
                    && (32'(i_in_data.pixel_index) < MAX_PIXELS);

    always_comb begin
        o_task       = '0;
        o_task.value = i_in_data.word_value;
        o_task.pix   = i_in_data.pixel_index;
        o_task.sig   = i_in_data.signal_sample;
        o_task.gsm   = i_in_data.gain_sample;
        o_push       = accept;
        if (!i_in_data.opcode) begin
            o_task.kind = K_LOAD;
            o_task.addr = ADDR_W'(i_in_data.word_address);
            // loads beyond the table are dropped
            if (32'(i_in_data.word_address) >= TABLE_DEPTH) o_push = 1'b0;
        end else if (r_mode == MODE_GAIN) begin
            o_task.kind = K_GAIN;
            o_task.addr = ADDR_W'(base);
            if (!in_image || !cell_ok
                || (32'(base) + 32'(WORDS_PER_PIXEL - 1)) >= TABLE_DEPTH)
                o_task.kind = K_ERR;
        end else if (r_mode == MODE_CELL_PED) begin
            o_task.kind = K_PED;
            o_task.addr = ADDR_W'(cell_addr);
            if (!in_image || !cell_ok || 32'(cell_addr) >= TABLE_DEPTH)
                o_task.kind = K_ERR;
        end else begin
            o_task.kind = K_PED;
            o_task.addr = ADDR_W'(i_in_data.pixel_index);
            if (!in_image || 32'(i_in_data.pixel_index) >= TABLE_DEPTH)
                o_task.kind = K_ERR;
        end
    end

endmodule
`default_nettype wire

@@ hdl/ppgc_fifo.sv @@
`default_nettype none
module ppgc_fifo (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  ppgc_pkg::t_task  i_data,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_valid,
    output ppgc_pkg::t_task  o_data
);
    import ppgc_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    t_task        r_mem [FIFO_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;
    logic          do_pop;
    logic          do_push;

    assign o_full  = r_cnt == (PW+1)'(FIFO_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;
    assign do_push = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            if (do_push && !do_pop) r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule
`default_nettype wire

@@ hdl/ppgc_div.sv @@
`default_nettype none
module ppgc_div (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire  [ppgc_pkg::DIV_NUM_W-1:0]   i_num,
    input  wire  [31:0]                      i_den,
    output logic                             o_done,
    output logic [ppgc_pkg::DIV_NUM_W-1:0]   o_quo
);
    import ppgc_pkg::*;

    localparam int CYC = DIV_NUM_W / DIV_STEPS;
    localparam int CW  = $clog2(CYC);

    logic [DIV_NUM_W-1:0] r_num, n_num;
    logic [31:0]          r_rem, n_rem;
    logic [31:0]          r_den;
    logic [CW-1:0]        r_cnt;
    logic                 r_run;
    logic                 r_done;

    // restoring division, two quotient bits a cycle
    always_comb begin
        logic [32:0] t;
        logic        ge;
        n_num = r_num;
        n_rem = r_rem;
        for (int k = 0; k < DIV_STEPS; k++) begin
            t     = {n_rem, n_num[DIV_NUM_W-1]};
            ge    = t >= {1'b0, r_den};
            n_num = {n_num[DIV_NUM_W-2:0], ge};
            n_rem = ge ? 32'(t - {1'b0, r_den}) : t[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_run) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(CYC - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;

endmodule
`default_nettype wire

@@ hdl/ppgc_back.sv @@
`default_nettype none
module ppgc_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_task_valid,
    input  ppgc_pkg::t_task     i_task,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output ppgc_pkg::t_out_item o_out_data
);
    import ppgc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PED  = 3'd1;
    localparam logic [2:0] S_G0   = 3'd2;
    localparam logic [2:0] S_G1   = 3'd3;
    localparam logic [2:0] S_G2   = 3'd4;
    localparam logic [2:0] S_G3   = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    localparam logic signed [33:0] SMAX = 34'sh0_7FFF_FFFF;
    localparam logic signed [33:0] SMIN = -34'sh0_8000_0000;

    logic [31:0]       r_table [TABLE_DEPTH];
    logic [31:0]       r_rdata;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;

    logic [2:0]        r_state, n_state;
    t_task             r_task;
    logic [1:0]        r_level;
    logic              r_neg;
    logic [31:0]       r_res;
    logic [1:0]        r_status;
    logic              r_out_valid;
    t_out_item         r_out;

    logic signed [33:0] sig_q8;
    logic signed [33:0] word_s;
    logic signed [33:0] diff;
    logic [31:0]        mag;
    logic               gt;
    logic               div_start;
    logic               div_done;
    logic [DIV_NUM_W-1:0] quo;
    logic [ADDR_W-1:0]  pair_addr;

    assign sig_q8    = $signed({10'b0, r_task.sig, 8'b0});
    assign word_s    = $signed({{2{r_rdata[31]}}, r_rdata});
    assign diff      = sig_q8 - word_s;
    assign mag       = diff[33] ? 32'(-diff) : diff[31:0];
    assign gt        = $signed({10'b0, r_task.gsm, 8'b0}) > word_s;
    assign pair_addr = r_task.addr + ADDR_W'(2) + ADDR_W'({r_level, 1'b0});

    // single-port table, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) r_table[mem_addr] <= i_task.value;
        else        r_rdata <= r_table[mem_addr];
    end

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        mem_we   = 1'b0;
        mem_addr = r_task.addr;
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                mem_addr = i_task.addr;
                if (i_task_valid) begin
                    o_pop = 1'b1;
                    unique case (i_task.kind)
                        K_LOAD:  mem_we  = 1'b1;
                        K_ERR:   n_state = S_DONE;
                        K_PED:   n_state = S_PED;
                        default: n_state = S_G0;
                    endcase
                end
            end
            S_PED:  n_state = S_DONE;
            S_G0: begin
                mem_addr = r_task.addr + ADDR_W'(1);
                n_state  = S_G1;
            end
            S_G1: begin
                mem_addr = r_task.addr + ADDR_W'(2)
                         + (gt ? ADDR_W'(4) : (r_level[0] ? ADDR_W'(2) : ADDR_W'(0)));
                n_state  = S_G2;
            end
            S_G2: begin
                mem_addr = pair_addr + ADDR_W'(1);
                n_state  = S_G3;
            end
            S_G3: begin
                if (r_rdata == '0) n_state = S_DONE;
                else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: if (div_done) n_state = S_DONE;
            S_DONE: if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    ppgc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({r_res, 16'b0}),
        .i_den   (r_rdata),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_task   <= i_task;
                r_level  <= 2'd0;
                r_res    <= '0;
                r_status <= (i_task.kind == K_ERR) ? ST_RANGE : ST_OK;
            end
            S_PED: begin
                if (diff > SMAX)      r_res <= 32'h7FFF_FFFF;
                else if (diff < SMIN) r_res <= 32'h8000_0000;
                else                  r_res <= diff[31:0];
            end
            S_G0: r_level <= gt ? 2'd1 : 2'd0;
            S_G1: if (gt) r_level <= 2'd2;
            S_G2: begin
                // offset-corrected magnitude feeds the divider
                r_res <= mag;
                r_neg <= diff[33];
            end
            S_G3: if (r_rdata == '0) begin
                r_status <= ST_ZERO_GAIN;
                r_res    <= '0;
            end
            S_DIV: if (div_done) begin
                if (!r_neg)
                    r_res <= (quo > DIV_NUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quo[31:0];
                else
                    r_res <= (quo > DIV_NUM_W'(32'h8000_0000)) ? 32'h8000_0000
                                                               : 32'(-quo[31:0]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && (!r_out_valid || i_out_ready)) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
            r_out.out_index  <= r_task.pix;
            r_out.calibrated <= r_res;
            r_out.gain_stage <= (r_status == ST_RANGE) ? 2'd0 : r_level;
            r_out.status     <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire
